>>> design/multi_stack_shared_free_list_assert.svh
// Assertion macros for the shared free-list stack block.
// Included by the top-level RTL file, which carries the concurrent checks; depends on nothing.
`ifndef MULTI_STACK_SHARED_FREE_LIST_ASSERT_SVH
`define MULTI_STACK_SHARED_FREE_LIST_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define MSFL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled while reset is high.
`define MSFL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MSFL_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define MSFL_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> design/msfl_pkg.sv
// Package for the shared free-list stack block: item types, codes and defaults.
// Used by every module of the block; depends on nothing.
package msfl_pkg;

   localparam int NUM_STACKS_DEF = 4;
   localparam int CAPACITY_DEF   = 16;
   localparam int VALUE_W        = 32;
   localparam int STACK_ID_W     = 2;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_POP  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [STACK_ID_W-1:0]  stack_id;
      logic signed [VALUE_W-1:0] push_value;
   } req_item_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] pop_value;
      status_type                status;
   } rsp_item_type;

   // Controls of the head table.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } head_ctl_type;

   // Controls of the slot store.
   typedef struct packed {
      logic rd_en;
      logic data_we;
      logic link_we;
   } slot_ctl_type;

endpackage

>>> design/multi_stack_shared_free_list.sv
// Several LIFO stacks kept in one shared store of CAPACITY slots, chained through a
// linked free list. Each item is a push or a pop on one stack and gives exactly one
// result: the popped value (zero on a push or an error) and a status of ok, overflow
// or underflow. From acceptance to a registered result, an item first reads the
// stack's head pointer, then reads the link and value of the slot concerned, and
// then updates the memories and loads the result. The chain of two dependent
// memory reads sets this order. A new item is accepted once the previous one has
// loaded its result, even if that result is still waiting to be taken; if the
// result register is full, the update cycle waits for it.
// No clearing pass follows reset: a fill count reproduces the initial free chain.
`include "multi_stack_shared_free_list_assert.svh"

module multi_stack_shared_free_list #(
   parameter int NUM_STACKS = msfl_pkg::NUM_STACKS_DEF,
   parameter int CAPACITY   = msfl_pkg::CAPACITY_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  msfl_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output msfl_pkg::rsp_item_type rsp_item
);
   import msfl_pkg::*;

   // Pointers carry one extra code, CAPACITY itself, meaning null.
   localparam int PTR_W     = $clog2(CAPACITY + 1);
   localparam int SID_IDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int SID_EXT_W = (SID_IDX_W > STACK_ID_W) ? SID_IDX_W : STACK_ID_W;
   localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_HEAD = 3'b010,
      S_SLOT = 3'b100
   } state_type;

   state_type    state_ff, state_in;
   req_item_type item_ff;
   logic [PTR_W-1:0] free_head_ff, free_head_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic         accept;
   logic         commit;
   logic         in_range;
   logic         push_ok;
   logic         pop_ok;

   logic [SID_EXT_W-1:0] req_sid_ext;
   logic [SID_EXT_W-1:0] item_sid_ext;
   logic [SID_IDX_W-1:0] req_sid_idx;
   logic [SID_IDX_W-1:0] item_sid_idx;

   head_ctl_type head_ctl;
   logic [PTR_W-1:0] head_wr_ptr;
   logic [PTR_W-1:0] head_ptr;

   slot_ctl_type slot_ctl;
   logic [PTR_W-1:0] slot_rd_addr;
   logic [PTR_W-1:0] slot_wr_addr;
   logic [PTR_W-1:0] slot_wr_link;
   logic signed [VALUE_W-1:0] slot_rd_data;
   logic [PTR_W-1:0] slot_rd_link;

   // Handshake. The head read is issued in the cycle the item is accepted.
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   // The update cycle completes only when the result register can take the result.
   assign commit    = (state_ff == S_SLOT) && (!rsp_valid_ff || rsp_ready);

   assign req_sid_ext  = SID_EXT_W'(req_item.stack_id);
   assign item_sid_ext = SID_EXT_W'(item_ff.stack_id);
   assign req_sid_idx  = req_sid_ext[SID_IDX_W-1:0];
   assign item_sid_idx = item_sid_ext[SID_IDX_W-1:0];

   // Stack numbers beyond the configured count change nothing and report an error.
   assign in_range = (32'(item_ff.stack_id) < 32'(NUM_STACKS));
   assign push_ok  = (item_ff.cmd == CMD_PUSH) && in_range && (free_head_ff != NULL_PTR);
   assign pop_ok   = (item_ff.cmd == CMD_POP) && in_range && (head_ptr != NULL_PTR);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            state_in = S_SLOT;
         end
         S_SLOT: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Memory controls. In the head cycle the slot of interest is read: the free-list
   // head for a push, the stack's top for a pop. Writes happen only at commit, and
   // the next item's reads come after that, so no forwarding is needed.
   always_comb begin
      head_ctl.rd_en = accept;
      head_ctl.wr_en = commit && (push_ok || pop_ok);
      head_wr_ptr    = push_ok ? free_head_ff : slot_rd_link;

      slot_ctl.rd_en   = (state_ff == S_HEAD);
      slot_ctl.data_we = commit && push_ok;
      slot_ctl.link_we = commit && (push_ok || pop_ok);
      slot_rd_addr     = (item_ff.cmd == CMD_PUSH) ? free_head_ff : head_ptr;
      slot_wr_addr     = push_ok ? free_head_ff : head_ptr;
      // A pushed slot links to the old top; a popped slot links to the free list.
      slot_wr_link     = push_ok ? head_ptr : free_head_ff;
   end

   always_comb begin
      free_head_in = free_head_ff;
      if (commit && push_ok) begin
         free_head_in = slot_rd_link;
      end else if (commit && pop_ok) begin
         free_head_in = head_ptr;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (commit) begin
         rsp_valid_in          = 1'b1;
         rsp_item_in.pop_value = pop_ok ? slot_rd_data : '0;
         if (item_ff.cmd == CMD_PUSH) begin
            rsp_item_in.status = push_ok ? ST_OK : ST_OVERFLOW;
         end else begin
            rsp_item_in.status = pop_ok ? ST_OK : ST_UNDERFLOW;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_head_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   msfl_head_table #(
      .NUM_STACKS (NUM_STACKS),
      .CAPACITY   (CAPACITY),
      .PTR_W      (PTR_W),
      .SID_IDX_W  (SID_IDX_W)
   ) u_head_table (
      .clock  (clock),
      .reset  (reset),
      .ctl    (head_ctl),
      .rd_idx (req_sid_idx),
      .wr_idx (item_sid_idx),
      .wr_ptr (head_wr_ptr),
      .rd_ptr (head_ptr)
   );

   msfl_slot_store #(
      .CAPACITY (CAPACITY),
      .PTR_W    (PTR_W)
   ) u_slot_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (slot_ctl),
      .rd_addr (slot_rd_addr),
      .wr_addr (slot_wr_addr),
      .wr_data (item_ff.push_value),
      .wr_link (slot_wr_link),
      .rd_data (slot_rd_data),
      .rd_link (slot_rd_link)
   );

   // A committed item always leaves a result in the output register.
   `MSFL_ASSERT_NXT(a_commit_loads_result, clock, reset, commit, rsp_valid_ff, "commit without result")
   // A successful pop puts the popped slot at the head of the free list.
   `MSFL_ASSERT_NXT(a_pop_frees_slot, clock, reset, commit && pop_ok, free_head_ff == $past(head_ptr), "popped slot not freed")
   // A successful push takes the free-list head's successor as the new free head.
   `MSFL_ASSERT_NXT(a_push_advances_free, clock, reset, commit && push_ok, free_head_ff == $past(slot_rd_link), "free list not advanced")
   // No item is accepted while another one is still being worked on.
   `MSFL_ASSERT_IMP(a_one_item_at_a_time, clock, reset, accept, state_ff == S_IDLE, "item accepted while busy")

endmodule

>>> design/msfl_head_table.sv
// Head pointer table: one top-of-stack pointer per stack in a synchronous memory.
// Valid bits make unwritten entries read as null. Depends on msfl_pkg.
module msfl_head_table #(
   parameter int NUM_STACKS = 4,
   parameter int CAPACITY   = 16,
   parameter int PTR_W      = 5,
   parameter int SID_IDX_W  = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  msfl_pkg::head_ctl_type ctl,
   input  logic [SID_IDX_W-1:0]  rd_idx,
   input  logic [SID_IDX_W-1:0]  wr_idx,
   input  logic [PTR_W-1:0]      wr_ptr,
   output logic [PTR_W-1:0]      rd_ptr
);
   import msfl_pkg::*;

   localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(CAPACITY);

   logic [PTR_W-1:0]      head_mem [0:NUM_STACKS-1];
   logic [NUM_STACKS-1:0] valid_ff;
   logic [NUM_STACKS-1:0] valid_in;
   logic [PTR_W-1:0]      rd_ptr_ff;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         head_mem[wr_idx] <= wr_ptr;
      end
      if (ctl.rd_en) begin
         rd_ptr_ff <= valid_ff[rd_idx] ? head_mem[rd_idx] : NULL_PTR;
      end
   end

   assign rd_ptr = rd_ptr_ff;

endmodule

>>> design/msfl_slot_store.sv
// Slot store: value and link memories, one read and one write port each.
// A fill count stands in for the reset chain of links. Depends on msfl_pkg.
module msfl_slot_store #(
   parameter int CAPACITY = 16,
   parameter int PTR_W    = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  msfl_pkg::slot_ctl_type        ctl,
   input  logic [PTR_W-1:0]              rd_addr,
   input  logic [PTR_W-1:0]              wr_addr,
   input  logic signed [msfl_pkg::VALUE_W-1:0] wr_data,
   input  logic [PTR_W-1:0]              wr_link,
   output logic signed [msfl_pkg::VALUE_W-1:0] rd_data,
   output logic [PTR_W-1:0]              rd_link
);
   import msfl_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);

   logic signed [VALUE_W-1:0] data_mem [0:CAPACITY-1];
   logic [PTR_W-1:0]          link_mem [0:CAPACITY-1];

   logic signed [VALUE_W-1:0] data_rd_ff;
   logic [PTR_W-1:0]          link_rd_ff;
   logic [PTR_W-1:0]          addr_ff;
   logic                      fresh_rd_ff;

   // Slots at or above the fill count have never been taken; their link is
   // implicitly the next slot, the last one linking to null.
   logic [PTR_W-1:0] fill_ff;
   logic [PTR_W-1:0] fill_in;

   always_comb begin
      fill_in = fill_ff;
      if (ctl.data_we && (wr_addr == fill_ff)) begin
         fill_in = fill_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.data_we) begin
         data_mem[wr_addr[IDX_W-1:0]] <= wr_data;
      end
      if (ctl.link_we) begin
         link_mem[wr_addr[IDX_W-1:0]] <= wr_link;
      end
      if (ctl.rd_en) begin
         data_rd_ff  <= data_mem[rd_addr[IDX_W-1:0]];
         link_rd_ff  <= link_mem[rd_addr[IDX_W-1:0]];
         addr_ff     <= rd_addr;
         fresh_rd_ff <= (rd_addr >= fill_ff);
      end
   end

   assign rd_data = data_rd_ff;
   assign rd_link = fresh_rd_ff ? (addr_ff + PTR_W'(1)) : link_rd_ff;

endmodule

>>> sim/tb.sv
// Testbench for multi_stack_shared_free_list: directed and random push and pop traffic
// with a shadow copy of the slot store that predicts every result in order.
// Depends on msfl_pkg and the block's top module; nothing else.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import msfl_pkg::*;

   // The shadow pointers use CAPACITY as the null value, so they need one bit more
   // than a slot index.
   localparam int PTR_W = $clog2(CAPACITY_DEF + 1);
   localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY_DEF);
   localparam int DRAIN_LIMIT = 5000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_item;

   multi_stack_shared_free_list dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the block's state. Pointers are always held normalised, so a
   // value of NIL is the only null that ever appears here.
   logic signed [VALUE_W-1:0] shadow_value [CAPACITY_DEF];
   logic [PTR_W-1:0]          shadow_link  [CAPACITY_DEF];
   logic [PTR_W-1:0]          shadow_top   [NUM_STACKS_DEF];
   logic [PTR_W-1:0]          shadow_free;
   int                        slots_used;

   // Results predicted for accepted items, oldest first.
   rsp_item_type pending_results[$];

   int errors = 0;
   int n_push = 0;
   int n_pop = 0;
   int n_overflow = 0;
   int n_underflow = 0;
   int n_checked = 0;

   // Sender pacing: bursts of random length separated by random gaps. Some phases
   // switch the gaps off so that items follow back to back.
   bit gaps_on = 1'b1;
   int burst_left = 0;

   // Works out the result of one item and updates the shadow state as the block
   // would. Stack numbers beyond the configured count are handled although the
   // two-bit field cannot reach them with four stacks.
   function automatic rsp_item_type apply_stack_op(input req_item_type it);
      rsp_item_type     res;
      logic [PTR_W-1:0] slot;
      int               sid;
      res.pop_value = '0;
      res.status    = ST_OK;
      sid = int'(it.stack_id);
      if (it.cmd == CMD_PUSH) begin
         n_push++;
         slot = shadow_free;
         if (sid >= NUM_STACKS_DEF || slot == NIL) begin
            res.status = ST_OVERFLOW;
            n_overflow++;
         end else begin
            shadow_free        = shadow_link[slot];
            shadow_value[slot] = it.push_value;
            shadow_link[slot]  = shadow_top[sid];
            shadow_top[sid]    = slot;
            slots_used++;
         end
      end else begin
         n_pop++;
         if (sid >= NUM_STACKS_DEF || shadow_top[sid] == NIL) begin
            res.status = ST_UNDERFLOW;
            n_underflow++;
         end else begin
            slot              = shadow_top[sid];
            shadow_top[sid]   = shadow_link[slot];
            shadow_link[slot] = shadow_free;
            shadow_free       = slot;
            res.pop_value     = shadow_value[slot];
            slots_used--;
         end
      end
      return res;
   endfunction

   function automatic req_item_type make_item(input cmd_type cmd, input int sid,
                                              input logic [VALUE_W-1:0] value);
      req_item_type it;
      it.cmd        = cmd;
      it.stack_id   = STACK_ID_W'(sid);
      it.push_value = value;
      return it;
   endfunction

   // Mostly full-range random values, with the extremes and small numbers mixed in.
   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'hffff_ffff;
         3:       return VALUE_W'($urandom_range(0, 15));
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   // Called at a rising edge, once the last item has been accepted. Valid is only
   // lowered when a gap follows, so it is never lowered and raised in one step.
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = gaps_on ? $urandom_range(1, 6) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   // Offers one item and holds it until the block takes it. The prediction is made
   // at the edge of acceptance, well before the result can come back.
   task automatic send_item(input req_item_type it);
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(apply_stack_op(it));
      pace_sender();
   endtask

   // A pop on an empty stack straight after reset must underflow and leave
   // everything as it was.
   task automatic test_empty_pop();
      send_item(make_item(CMD_POP, 0, 32'h1234_5678));
   endtask

   // The extremes of the value range go in on separate stacks, and two of them come back
   // out unchanged; a second pop of stack 1 then underflows.
   task automatic test_value_extremes();
      send_item(make_item(CMD_PUSH, 0, 32'h7fff_ffff));
      send_item(make_item(CMD_PUSH, 1, 32'h8000_0000));
      send_item(make_item(CMD_PUSH, 2, 32'h0000_0000));
      send_item(make_item(CMD_PUSH, 3, 32'hffff_ffff));
      send_item(make_item(CMD_POP, 1, 32'hffff_ffff));
      send_item(make_item(CMD_POP, 3, 32'h0000_0000));
      send_item(make_item(CMD_POP, 1, 32'h0000_0000));
   endtask

   // Fills every slot, so that the free list runs dry, checks overflow, then frees
   // one slot and pushes again to see it reused.
   task automatic test_full_store();
      int i;
      for (i = 0; i < CAPACITY_DEF; i++) begin
         if (slots_used < CAPACITY_DEF)
            send_item(make_item(CMD_PUSH, i % NUM_STACKS_DEF, VALUE_W'(32'hA500_0000 + i)));
      end
      send_item(make_item(CMD_PUSH, 2, 32'hdead_beef));
      send_item(make_item(CMD_POP, 0, 32'h0));
      send_item(make_item(CMD_PUSH, 0, 32'h0bad_f00d));
   endtask

   // Random traffic in phases. Each phase has its own push ratio, so the store is
   // driven full and empty again many times, and some phases aim at one stack so
   // that long chains build up through the shared free list.
   task automatic test_random_traffic();
      int phase;
      int k;
      int push_pct;
      int focus;
      int sid;
      cmd_type cmd;
      for (phase = 0; phase < 8; phase++) begin
         case ($urandom_range(0, 3))
            0:       push_pct = 15;
            1:       push_pct = 50;
            2:       push_pct = 85;
            default: push_pct = 97;
         endcase
         focus   = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 3)) : -1;
         gaps_on = (phase % 3) != 1;
         for (k = 0; k < 75; k++) begin
            cmd = ($urandom_range(1, 100) <= push_pct) ? CMD_PUSH : CMD_POP;
            if (focus >= 0 && $urandom_range(0, 3) != 0)
               sid = focus;
            else
               sid = $urandom_range(0, NUM_STACKS_DEF - 1);
            send_item(make_item(cmd, sid, pick_value()));
         end
      end
      gaps_on = 1'b1;
   endtask

   // The receiver stalls on a pattern of its own that changes every so often:
   // always ready, mostly ready, mostly stalled, or a fixed on-off rhythm.
   int stall_mode = 0;
   int mode_left = 0;
   int stall_tick = 0;
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      stall_tick++;
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 3) != 0);
         2:       rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= ((stall_tick % 7) < 3);
      endcase
   end

   // Every result the block hands over is compared with the oldest prediction.
   always @(posedge clock) begin : result_checker
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with no item outstanding: pop_value %h status %0d",
                     $time, rsp_item.pop_value, rsp_item.status);
            errors++;
         end else begin
            want = pending_results.pop_front();
            n_checked++;
            if (rsp_item.pop_value !== want.pop_value) begin
               $display("%0t: pop_value expected %h actual %h",
                        $time, want.pop_value, rsp_item.pop_value);
               errors++;
            end
            if (rsp_item.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_item.status);
               errors++;
            end
         end
      end
   end

   initial begin : stimulus
      int i;
      int waited;
      for (i = 0; i < CAPACITY_DEF; i++) begin
         shadow_value[i] = '0;
         shadow_link[i]  = PTR_W'(i + 1);
      end
      for (i = 0; i < NUM_STACKS_DEF; i++)
         shadow_top[i] = NIL;
      shadow_free = '0;
      slots_used  = 0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_empty_pop();
      test_value_extremes();
      test_full_store();
      test_random_traffic();

      // All items are in; let the outstanding results drain, then keep watching
      // in case anything spurious follows.
      req_valid <= 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, pending_results.size());
         errors++;
      end

      $display("tb: %0d pushes (%0d overflowed), %0d pops (%0d underflowed)",
               n_push, n_overflow, n_pop, n_underflow);
      $display("tb: %0d results checked across four stacks sharing %0d slots",
               n_checked, CAPACITY_DEF);
      if (errors == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

   // Far beyond the slowest correct run.
   initial begin : watchdog
      #2_000_000;
      $display("tb: errors");
      $finish;
   end

endmodule
